// ===== rtl/itra_pkg.sv =====
// Shared types, codes and constants for the integer to radix ASCII converter.
package itra_pkg;

    typedef enum logic [2:0] {
        CMD_BIN  = 3'd0,
        CMD_OCT  = 3'd1,
        CMD_UDEC = 3'd2,
        CMD_SDEC = 3'd3,
        CMD_HEX  = 3'd4
    } t_command;

    // Fixed-point reciprocal of ten: q = (x * RECIP10) >> RECIP10_SHIFT for any 32-bit x.
    localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int          RECIP10_SHIFT = 35;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ALPHA = 8'h57;  // 'a' minus ten
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take a new word
        logic mul;         // register the quotient by ten
        logic push;        // push one digit, shift the magnitude down
        logic emit_sign;   // put '-' in the output register
        logic emit_digit;  // pop one digit into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_dec;      // current word converts in decimal
        logic neg;         // sign still to be sent
        logic next_zero;   // magnitude after this push is zero
        logic cnt_one;     // one digit left on the stack
        logic out_free;    // output register can take a character
    } t_dp_sts;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] base;
        base = (d < 4'd10) ? CHAR_ZERO : CHAR_ALPHA;
        return base + {4'b0000, d};
    endfunction

endpackage

// ===== rtl/integer_to_radix_ascii.sv =====
// Top level of the integer to radix ASCII converter: controller plus datapath.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+------------------------------------------
//  input   | i_valid | o_stall | i_value[31:0], i_command[2:0]
//  output  | o_valid | i_stall | o_character[7:0], o_last
//
// Per word: an accept step, then one push per digit in binary, octal and hex,
// or a quotient step and a push per digit in decimal (registered multiply by
// the reciprocal of ten, then remainder and push), then one pop per character
// out of the digit stack (plus one output for '-').
// Reset is synchronous and active low; it clears the state machine, the stack
// count and the output valid. Output stalls hold the character register and
// pause the stack pops; input is stalled whenever a word is in progress.
module integer_to_radix_ascii #(
    parameter int DATA_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_value,
    input  logic [2:0]  i_command,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_character,
    output logic        o_last
);

    itra_pkg::t_dp_cmd w_cmd;
    itra_pkg::t_dp_sts w_sts;

    // Controller: idle, quotient, push and emit states.
    itra_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts)
    );

    // Datapath: digits are produced least significant first and pushed,
    // then popped most significant first into the output register.
    itra_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_command   (i_command),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_character (o_character),
        .o_last      (o_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall)
    );

endmodule

// ===== rtl/itra_dp.sv =====
// Datapath: magnitude register, divide-by-ten step, digit stack and output register.
module itra_dp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [31:0]           i_value,
    input  logic [2:0]            i_command,
    input  itra_pkg::t_dp_cmd     i_cmd,
    output itra_pkg::t_dp_sts     o_sts,
    output logic [7:0]            o_character,
    output logic                  o_last,
    output logic                  o_valid,
    input  logic                  i_stall
);

    localparam int IW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_mag;
    logic [DATA_WIDTH-1:0] n_mag;
    logic [DATA_WIDTH-1:0] r_quot;
    itra_pkg::t_command    r_rad;
    logic                  r_neg;
    logic [3:0]            r_stack [DATA_WIDTH];
    logic [CW-1:0]         r_cnt;
    logic [7:0]            r_char;
    logic                  r_last;
    logic                  r_oval;

    logic [DATA_WIDTH-1:0] w_in;
    logic                  w_in_neg;
    logic [31:0]           w_mag32;
    logic [63:0]           w_prod;
    logic [28:0]           w_q29;
    logic [3:0]            w_q10_lo;
    logic [3:0]            w_rem;
    logic [3:0]            w_digit;
    logic [CW-1:0]         w_top;
    logic [IW-1:0]         w_pop_idx;
    logic [IW-1:0]         w_push_idx;

    assign w_in     = i_value[DATA_WIDTH-1:0];
    assign w_in_neg = (i_command == itra_pkg::CMD_SDEC) && w_in[DATA_WIDTH-1];

    // Quotient by ten: one 32x32 multiply, registered before use.
    assign w_mag32 = 32'(r_mag);
    assign w_prod  = w_mag32 * itra_pkg::RECIP10;
    assign w_q29   = w_prod[63:itra_pkg::RECIP10_SHIFT];

    // Remainder needs only the low nibble since it is below ten.
    assign w_q10_lo = 4'({r_quot[0], 3'b000}) + {r_quot[2:0], 1'b0};
    assign w_rem    = r_mag[3:0] - w_q10_lo;

    always_comb begin
        case (r_rad)
            itra_pkg::CMD_BIN: begin
                w_digit = {3'b000, r_mag[0]};
                n_mag   = r_mag >> 1;
            end
            itra_pkg::CMD_OCT: begin
                w_digit = {1'b0, r_mag[2:0]};
                n_mag   = r_mag >> 3;
            end
            itra_pkg::CMD_HEX: begin
                w_digit = r_mag[3:0];
                n_mag   = r_mag >> 4;
            end
            default: begin
                w_digit = w_rem;
                n_mag   = r_quot;
            end
        endcase
    end

    assign w_top      = r_cnt - CW'(1);
    assign w_pop_idx  = w_top[IW-1:0];
    assign w_push_idx = r_cnt[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= w_in_neg ? DATA_WIDTH'(~w_in + DATA_WIDTH'(1)) : w_in;
            r_rad <= itra_pkg::t_command'(i_command);
        end else if (i_cmd.push) begin
            r_mag <= n_mag;
        end
        if (i_cmd.mul) begin
            r_quot <= DATA_WIDTH'(w_q29);
        end
        if (i_cmd.push) begin
            r_stack[w_push_idx] <= w_digit;
        end
        if (i_cmd.emit_sign) begin
            r_char <= itra_pkg::CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_char <= itra_pkg::digit_char(r_stack[w_pop_idx]);
            r_last <= (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_neg  <= 1'b0;
            r_oval <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
                r_neg <= w_in_neg;
            end else if (i_cmd.push) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.emit_digit) begin
                r_cnt <= w_top;
            end
            if (i_cmd.emit_sign) begin
                r_neg <= 1'b0;
            end
            if (i_cmd.emit_sign || i_cmd.emit_digit) begin
                r_oval <= 1'b1;
            end else if (!i_stall) begin
                r_oval <= 1'b0;
            end
        end
    end

    assign o_sts.is_dec    = (r_rad == itra_pkg::CMD_UDEC) || (r_rad == itra_pkg::CMD_SDEC);
    assign o_sts.neg       = r_neg;
    assign o_sts.next_zero = (n_mag == '0);
    assign o_sts.cnt_one   = (r_cnt == CW'(1));
    assign o_sts.out_free  = !r_oval || !i_stall;

    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_valid     = r_oval;

    // The stack never holds more digits than the word has bits.
    a_push_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (r_cnt < CW'(DATA_WIDTH)))
        else $error("digit stack overflow");

    // A pop always finds a digit.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_digit |-> (r_cnt != '0))
        else $error("pop from empty digit stack");

    // The sign goes out only while a sign is pending and digits are on the stack.
    a_sign_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_sign |-> (r_cnt != '0) && r_neg)
        else $error("sign emitted without pending digits");

endmodule

// ===== rtl/itra_ctrl.sv =====
// Controller: sequences load, digit generation and character output.
module itra_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [2:0]            i_command,
    output logic                  o_stall,
    output itra_pkg::t_dp_cmd     o_cmd,
    input  itra_pkg::t_dp_sts     i_sts
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_PUSH = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_cmd_ok;
    logic   w_cmd_dec;

    assign w_cmd_ok  = (i_command == itra_pkg::CMD_BIN)  || (i_command == itra_pkg::CMD_OCT) ||
                       (i_command == itra_pkg::CMD_UDEC) || (i_command == itra_pkg::CMD_SDEC) ||
                       (i_command == itra_pkg::CMD_HEX);
    assign w_cmd_dec = (i_command == itra_pkg::CMD_UDEC) || (i_command == itra_pkg::CMD_SDEC);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                // Unused commands are taken and dropped.
                if (i_valid && w_cmd_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = w_cmd_dec ? S_MUL : S_PUSH;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_sts.next_zero) begin
                    n_state = S_EMIT;
                end else if (i_sts.is_dec) begin
                    n_state = S_MUL;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    if (i_sts.neg) begin
                        o_cmd.emit_sign = 1'b1;
                    end else begin
                        o_cmd.emit_digit = 1'b1;
                        if (i_sts.cnt_one) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // Generation ends as soon as the magnitude runs out.
    a_push_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) && i_sts.next_zero |=> (r_state == S_EMIT))
        else $error("digit generation did not stop at zero");

    // Only one datapath action per cycle.
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("conflicting datapath commands");

endmodule
